### design/rgbovl_pkg.sv
// ----------------------------------------------------------------------------
// rgbovl_pkg
// Shared constants for the RGB watermark overlay blender: field widths,
// register indexes and BT.601 conversion coefficients.
// ----------------------------------------------------------------------------
package rgbovl_pkg;

   // Item field widths
   localparam int LOGO_POS_W  = 10;
   localparam int FRAME_POS_W = 13;
   localparam int OFFSET_W    = 12;
   localparam int PIX_W       = 8;

   // Packed channel widths (data channels in whole bytes)
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 3;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OPACITY      = 3'd0,
      CSR_OFFSET_ROW   = 3'd1,
      CSR_OFFSET_COL   = 3'd2,
      CSR_FRAME_WIDTH  = 3'd3,
      CSR_FRAME_HEIGHT = 3'd4
   } csr_index_type;

   // Register reset values
   localparam logic [7:0]             OPACITY_RST      = 8'd255;
   localparam logic [FRAME_POS_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
   localparam logic [FRAME_POS_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

   // Largest frame dimension honored by the bounds check
   localparam logic [FRAME_POS_W-1:0] FRAME_DIM_MAX = 13'd4096;

   // BT.601 studio range coefficients (magnitudes; signs applied in the sums)
   localparam logic [7:0] C_Y_R  = 8'd66;
   localparam logic [7:0] C_Y_G  = 8'd129;
   localparam logic [7:0] C_Y_B  = 8'd25;
   localparam logic [7:0] C_CB_R = 8'd38;
   localparam logic [7:0] C_CB_G = 8'd74;
   localparam logic [7:0] C_CB_B = 8'd112;
   localparam logic [7:0] C_CR_R = 8'd112;
   localparam logic [7:0] C_CR_G = 8'd94;
   localparam logic [7:0] C_CR_B = 8'd18;
   localparam logic [7:0] C_ROUND      = 8'd128;
   localparam logic [7:0] C_LUMA_OFS   = 8'd16;
   localparam logic [7:0] C_CHROMA_OFS = 8'd128;
   localparam logic [7:0] C_FULL_SCALE = 8'd255;

endpackage

### design/rgb_overlay_yuv420_alpha_blend.sv
// ----------------------------------------------------------------------------
// rgb_overlay_yuv420_alpha_blend
// Places one RGB watermark pixel into a YUV 4:2:0 frame: converts it to
// BT.601 YCbCr, alpha-blends each component with the background samples and
// flags which of the luma and chroma planes take the result.
// ----------------------------------------------------------------------------
//
//  Channel  Ports             Direction  Item
//  -------  ----------------  ---------  --------------------------------------
//  req      req_t*            in         logo pixel, RGB and background Y/Cb/Cr
//  rsp      rsp_t*            out        frame position, blended Y/Cb/Cr, flags
//  csr      csr_*             in         register write, no read-back
//
//  One item per cycle is sustained while rsp_tready stays high, set by the four
//  register stages (products, sums, blend products, divide), each of which takes
//  a new item every clock unless the stage after it is stalled.
//  reset is synchronous: it empties every stage and loads register defaults.
//  A stall on rsp backs up stage by stage; a stage with a bubble still takes
//  an item, so req_tready stays high while any stage is free.
//  Write registers only while the pipeline is empty; a write takes effect at
//  the next edge.
// ----------------------------------------------------------------------------
module rgb_overlay_yuv420_alpha_blend (
   input  logic                                 clock,
   input  logic                                 reset,
   // lowest bit up: logo_row, logo_col, red, green, blue, bg_luma, bg_cb,
   // bg_cr, zero fill
   input  logic [rgbovl_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // lowest bit up: frame_row, frame_col, out_luma, out_cb, out_cr, zero fill
   output logic [rgbovl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // lowest bit up: write_luma, write_cb, write_cr
   output logic [rgbovl_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_wr_en,
   input  logic [rgbovl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rgbovl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rgbovl_pkg::*;

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic [7:0]             opacity_ff;
   logic [OFFSET_W-1:0]    offset_row_ff;
   logic [OFFSET_W-1:0]    offset_col_ff;
   logic [FRAME_POS_W-1:0] frame_width_ff;
   logic [FRAME_POS_W-1:0] frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff      <= OPACITY_RST;
         offset_row_ff   <= '0;
         offset_col_ff   <= '0;
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OPACITY:      opacity_ff      <= csr_wdata[7:0];
            CSR_OFFSET_ROW:   offset_row_ff   <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET_COL:   offset_col_ff   <= csr_wdata[OFFSET_W-1:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;  // unknown index: drop the write
         endcase
      end
   end

   // Clip frame dimensions to the largest supported frame
   logic [FRAME_POS_W-1:0] frame_w_lim;
   logic [FRAME_POS_W-1:0] frame_h_lim;
   assign frame_w_lim = (frame_width_ff  > FRAME_DIM_MAX) ? FRAME_DIM_MAX : frame_width_ff;
   assign frame_h_lim = (frame_height_ff > FRAME_DIM_MAX) ? FRAME_DIM_MAX : frame_height_ff;

   // -------------------------------------------------------------------------
   // Input unpack
   // -------------------------------------------------------------------------
   logic [LOGO_POS_W-1:0] in_logo_row;
   logic [LOGO_POS_W-1:0] in_logo_col;
   logic [PIX_W-1:0]      in_red, in_green, in_blue;
   logic [PIX_W-1:0]      in_bg_luma, in_bg_cb, in_bg_cr;

   assign in_logo_row = req_tdata[9:0];
   assign in_logo_col = req_tdata[19:10];
   assign in_red      = req_tdata[27:20];
   assign in_green    = req_tdata[35:28];
   assign in_blue     = req_tdata[43:36];
   assign in_bg_luma  = req_tdata[51:44];
   assign in_bg_cb    = req_tdata[59:52];
   assign in_bg_cr    = req_tdata[67:60];

   // -------------------------------------------------------------------------
   // Stage enables: a stage advances when it is empty or its successor moves
   // -------------------------------------------------------------------------
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic s1_en, s2_en, s3_en, s4_en;

   assign s4_en = !s4_vld_ff || rsp_tready;
   assign s3_en = !s3_vld_ff || s4_en;
   assign s2_en = !s2_vld_ff || s3_en;
   assign s1_en = !s1_vld_ff || s2_en;

   assign req_tready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         if (s1_en) s1_vld_ff <= req_tvalid;
         if (s2_en) s2_vld_ff <= s1_vld_ff;
         if (s3_en) s3_vld_ff <= s2_vld_ff;
         if (s4_en) s4_vld_ff <= s3_vld_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 1: frame position and the nine coefficient products
   // -------------------------------------------------------------------------
   logic [FRAME_POS_W-1:0] s1_row_ff, s1_col_ff;
   logic [15:0] s1_yr_ff, s1_yg_ff, s1_yb_ff;
   logic [15:0] s1_ur_ff, s1_ug_ff, s1_ub_ff;
   logic [15:0] s1_vr_ff, s1_vg_ff, s1_vb_ff;
   logic [PIX_W-1:0] s1_bg_y_ff, s1_bg_u_ff, s1_bg_v_ff;

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_row_ff  <= FRAME_POS_W'(in_logo_row) + FRAME_POS_W'(offset_row_ff);
         s1_col_ff  <= FRAME_POS_W'(in_logo_col) + FRAME_POS_W'(offset_col_ff);
         s1_yr_ff   <= 16'(in_red)   * 16'(C_Y_R);
         s1_yg_ff   <= 16'(in_green) * 16'(C_Y_G);
         s1_yb_ff   <= 16'(in_blue)  * 16'(C_Y_B);
         s1_ur_ff   <= 16'(in_red)   * 16'(C_CB_R);
         s1_ug_ff   <= 16'(in_green) * 16'(C_CB_G);
         s1_ub_ff   <= 16'(in_blue)  * 16'(C_CB_B);
         s1_vr_ff   <= 16'(in_red)   * 16'(C_CR_R);
         s1_vg_ff   <= 16'(in_green) * 16'(C_CR_G);
         s1_vb_ff   <= 16'(in_blue)  * 16'(C_CR_B);
         s1_bg_y_ff <= in_bg_luma;
         s1_bg_u_ff <= in_bg_cb;
         s1_bg_v_ff <= in_bg_cr;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 2: YCbCr sums with floor shift, bounds check
   // -------------------------------------------------------------------------
   // Chroma sums are signed; modular 18-bit arithmetic gives the right bits and
   // bits [15:8] are the arithmetic shift by eight.
   logic [16:0] y_sum;
   logic [17:0] u_sum, v_sum;
   logic        s2_inside_in;

   assign y_sum = 17'(s1_yr_ff) + 17'(s1_yg_ff) + 17'(s1_yb_ff) + 17'(C_ROUND);
   assign u_sum = 18'(s1_ub_ff) - 18'(s1_ur_ff) - 18'(s1_ug_ff) + 18'(C_ROUND);
   assign v_sum = 18'(s1_vr_ff) - 18'(s1_vg_ff) - 18'(s1_vb_ff) + 18'(C_ROUND);

   // Logo coordinates are ten bits wide, so they always sit inside the logo.
   assign s2_inside_in = (s1_row_ff < frame_h_lim) && (s1_col_ff < frame_w_lim);

   logic [FRAME_POS_W-1:0] s2_row_ff, s2_col_ff;
   logic [PIX_W-1:0] s2_wm_y_ff, s2_wm_u_ff, s2_wm_v_ff;
   logic [PIX_W-1:0] s2_bg_y_ff, s2_bg_u_ff, s2_bg_v_ff;
   logic             s2_inside_ff;

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_row_ff    <= s1_row_ff;
         s2_col_ff    <= s1_col_ff;
         s2_wm_y_ff   <= y_sum[15:8] + C_LUMA_OFS;
         s2_wm_u_ff   <= u_sum[15:8] + C_CHROMA_OFS;
         s2_wm_v_ff   <= v_sum[15:8] + C_CHROMA_OFS;
         s2_bg_y_ff   <= s1_bg_y_ff;
         s2_bg_u_ff   <= s1_bg_u_ff;
         s2_bg_v_ff   <= s1_bg_v_ff;
         s2_inside_ff <= s2_inside_in;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 3: blend products, watermark by opacity and background by the rest
   // -------------------------------------------------------------------------
   logic [PIX_W-1:0] inv_opacity;
   assign inv_opacity = C_FULL_SCALE - opacity_ff;

   logic [FRAME_POS_W-1:0] s3_row_ff, s3_col_ff;
   logic [15:0] s3_wy_ff, s3_wu_ff, s3_wv_ff;
   logic [15:0] s3_by_ff, s3_bu_ff, s3_bv_ff;
   logic        s3_inside_ff;

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_row_ff    <= s2_row_ff;
         s3_col_ff    <= s2_col_ff;
         s3_wy_ff     <= 16'(s2_wm_y_ff) * 16'(opacity_ff);
         s3_wu_ff     <= 16'(s2_wm_u_ff) * 16'(opacity_ff);
         s3_wv_ff     <= 16'(s2_wm_v_ff) * 16'(opacity_ff);
         s3_by_ff     <= 16'(s2_bg_y_ff) * 16'(inv_opacity);
         s3_bu_ff     <= 16'(s2_bg_u_ff) * 16'(inv_opacity);
         s3_bv_ff     <= 16'(s2_bg_v_ff) * 16'(inv_opacity);
         s3_inside_ff <= s2_inside_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 4: sum and divide by 255, then the output register
   // -------------------------------------------------------------------------
   // Both terms are nonnegative and their sum is at most 255*255, so the
   // quotient fits eight bits and needs no clamp. For x below 65535,
   // x / 255 == (x + 1 + (x >> 8)) >> 8.
   function automatic logic [PIX_W-1:0] div255(input logic [15:0] wm_p,
                                               input logic [15:0] bg_p);
      logic [16:0] x;
      logic [16:0] t;
      x = 17'(wm_p) + 17'(bg_p);
      t = x + 17'd1 + (x >> 8);
      return t[15:8];
   endfunction

   logic [FRAME_POS_W-1:0] s4_row_ff, s4_col_ff;
   logic [PIX_W-1:0]       s4_y_ff, s4_u_ff, s4_v_ff;
   logic                   s4_wr_y_ff, s4_wr_u_ff, s4_wr_v_ff;

   always_ff @(posedge clock) begin
      if (s4_en) begin
         s4_row_ff  <= s3_row_ff;
         s4_col_ff  <= s3_col_ff;
         s4_y_ff    <= div255(s3_wy_ff, s3_by_ff);
         s4_u_ff    <= div255(s3_wu_ff, s3_bu_ff);
         s4_v_ff    <= div255(s3_wv_ff, s3_bv_ff);
         // Cb on even row and column, Cr on even row and odd column
         s4_wr_y_ff <= s3_inside_ff;
         s4_wr_u_ff <= s3_inside_ff && !s3_row_ff[0] && !s3_col_ff[0];
         s4_wr_v_ff <= s3_inside_ff && !s3_row_ff[0] &&  s3_col_ff[0];
      end
   end

   assign rsp_tvalid = s4_vld_ff;
   assign rsp_tdata  = {6'd0, s4_v_ff, s4_u_ff, s4_y_ff, s4_col_ff, s4_row_ff};
   assign rsp_tuser  = {s4_wr_v_ff, s4_wr_u_ff, s4_wr_y_ff};

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   a_chroma_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[1] && rsp_tuser[2]))
      else $error("Cb and Cr write flags both set");

   a_chroma_needs_luma: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1] || rsp_tuser[2]) |-> rsp_tuser[0])
      else $error("chroma write flagged outside the frame");

   a_chroma_even_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1] || rsp_tuser[2]) |-> !rsp_tdata[0])
      else $error("chroma write flagged on an odd row");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output drains");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

### sim/rgb_overlay_yuv420_alpha_blend_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_overlay_yuv420_alpha_blend_tb
// Self-checking bench for the watermark overlay blender. A queue-fed driver
// streams logo pixels and a clocked monitor compares every result field with
// an in-bench model of the BT.601 conversion, the alpha blend and the frame
// bounds. Phases move through the register settings and the idle patterns.
// ----------------------------------------------------------------------------
module rgb_overlay_yuv420_alpha_blend_tb;
   import rgbovl_pkg::*;

   localparam int          HALF_PERIOD    = 5;
   localparam int          RESET_CYCLES   = 6;
   localparam int          DRAIN_CYCLES   = 8;
   localparam int          HOLD_CYCLES    = 400;   // long receiver hold-off
   localparam int          WATCHDOG_LIMIT = 4000;  // cycles with no item moving
   localparam int          RANDOM_ITEMS   = 171;   // per phase
   localparam int          LOGO_DIM_MAX   = 1024;
   localparam int          DIM_CLAMP      = 4096;
   localparam logic [2:0]  CSR_SPARE_INDEX = 3'd7; // no register behind it
   localparam int          REPORT_LINES   = 40;

   typedef struct packed {
      logic [7:0] bg_cr;
      logic [7:0] bg_cb;
      logic [7:0] bg_luma;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [9:0] logo_col;
      logic [9:0] logo_row;
   } pixel_type;

   typedef struct packed {
      logic [12:0] frame_row;
      logic [12:0] frame_col;
      logic [7:0]  out_luma;
      logic [7:0]  out_cb;
      logic [7:0]  out_cr;
      logic        write_luma;
      logic        write_cb;
      logic        write_cr;
   } overlay_type;

   // DUT connections; every input starts at a known value
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Shadow of the register file, as the block holds it after reset
   logic [7:0]  opacity_cfg    = 8'd255;
   logic [11:0] offset_row_cfg = 12'd0;
   logic [11:0] offset_col_cfg = 12'd0;
   logic [12:0] width_cfg      = 13'd1920;
   logic [12:0] height_cfg     = 13'd1080;

   pixel_type   pending_pixels[$];     // items waiting for the driver
   overlay_type expected_overlays[$];  // predictions for accepted items
   pixel_type   pixel_on_bus;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_seq       = 0;          // bumped by the stimulus to ask for a hold-off
   int hold_seen      = 0;
   int hold_left      = 0;
   int error_count    = 0;
   int results_seen   = 0;
   int quiet_cycles   = 0;

   rgb_overlay_yuv420_alpha_blend dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Blend one component: weight by opacity/255, truncate, clamp to a byte.
   function automatic int blend_component(int wm, int bg, int alpha);
      int mixed;
      mixed = (wm * alpha + bg * (255 - alpha)) / 255;
      if (mixed < 0) mixed = 0;
      if (mixed > 255) mixed = 255;
      return mixed;
   endfunction

   function automatic int clamp_dim(logic [12:0] dim);
      return (int'(dim) > DIM_CLAMP) ? DIM_CLAMP : int'(dim);
   endfunction

   // Work out the result for one pixel under the current register shadow.
   function automatic overlay_type predict_overlay(pixel_type px);
      overlay_type res;
      int r, g, b, y, u, v, alpha, frow, fcol;
      bit in_frame;
      r     = int'(px.red);
      g     = int'(px.green);
      b     = int'(px.blue);
      alpha = int'(opacity_cfg);
      // arithmetic shift on int floors negative sums, as the conversion needs
      y = ((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16;
      u = ((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128;
      v = ((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128;
      frow = (int'(px.logo_row) + int'(offset_row_cfg)) & 13'h1FFF;
      fcol = (int'(px.logo_col) + int'(offset_col_cfg)) & 13'h1FFF;
      in_frame = frow < clamp_dim(height_cfg) && fcol < clamp_dim(width_cfg) &&
                 int'(px.logo_row) < LOGO_DIM_MAX && int'(px.logo_col) < LOGO_DIM_MAX;
      res.frame_row  = frow[12:0];
      res.frame_col  = fcol[12:0];
      res.out_luma   = 8'(blend_component(y, int'(px.bg_luma), alpha));
      res.out_cb     = 8'(blend_component(u, int'(px.bg_cb), alpha));
      res.out_cr     = 8'(blend_component(v, int'(px.bg_cr), alpha));
      res.write_luma = in_frame;
      res.write_cb   = in_frame && !frow[0] && !fcol[0];
      res.write_cr   = in_frame && !frow[0] && fcol[0];
      return res;
   endfunction

   // Pick a logo coordinate: near a reachable frame edge half the time, else anywhere.
   function automatic logic [9:0] pick_coord(int bound);
      int c;
      if (bound >= 0 && bound <= LOGO_DIM_MAX + 3 && $urandom_range(1) == 1) begin
         c = bound - 4 + int'($urandom_range(8));
         if (c < 0) c = 0;
         if (c > LOGO_DIM_MAX - 1) c = LOGO_DIM_MAX - 1;
      end else begin
         c = int'($urandom_range(LOGO_DIM_MAX - 1));
      end
      return c[9:0];
   endfunction

   function automatic logic [7:0] pick_byte();
      // lean on the extremes now and then
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      px.logo_row = pick_coord(clamp_dim(height_cfg) - int'(offset_row_cfg));
      px.logo_col = pick_coord(clamp_dim(width_cfg) - int'(offset_col_cfg));
      px.red      = pick_byte();
      px.green    = pick_byte();
      px.blue     = pick_byte();
      px.bg_luma  = pick_byte();
      px.bg_cb    = pick_byte();
      px.bg_cr    = pick_byte();
      return px;
   endfunction

   function automatic pixel_type make_pixel(int row, int col, int r, int g, int b,
                                            int by, int bu, int bv);
      pixel_type px;
      px.logo_row = 10'(row);
      px.logo_col = 10'(col);
      px.red      = 8'(r);
      px.green    = 8'(g);
      px.blue     = 8'(b);
      px.bg_luma  = 8'(by);
      px.bg_cb    = 8'(bu);
      px.bg_cr    = 8'(bv);
      return px;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= REPORT_LINES) $display("[%0t] result %0d: %s", $realtime,
                                                results_seen, msg);
   endtask

   // Write one register and mirror it in the shadow copy.
   task automatic write_reg(logic [2:0] idx, logic [12:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_OPACITY:      opacity_cfg    = value[7:0];
         CSR_OFFSET_ROW:   offset_row_cfg = value[11:0];
         CSR_OFFSET_COL:   offset_col_cfg = value[11:0];
         CSR_FRAME_WIDTH:  width_cfg      = value;
         CSR_FRAME_HEIGHT: height_cfg     = value;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hold until the driver is empty and every prediction has been matched,
   // then give the pipeline time to settle before touching registers.
   task automatic wait_idle();
      while (pending_pixels.size() != 0 || req_tvalid || expected_overlays.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(logic [7:0] op, logic [11:0] orow, logic [11:0] ocol,
                            logic [12:0] fw, logic [12:0] fh, int idle, int stall,
                            bit squeeze);
      wait_idle();
      write_reg(CSR_OPACITY, 13'(op));
      write_reg(CSR_OFFSET_ROW, 13'(orow));
      write_reg(CSR_OFFSET_COL, 13'(ocol));
      write_reg(CSR_FRAME_WIDTH, fw);
      write_reg(CSR_FRAME_HEIGHT, fh);
      @(negedge clock);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      for (int k = 0; k < RANDOM_ITEMS; k++) pending_pixels.push_back(random_pixel());
      // ask for a long hold-off while the queue is full, so the input backs up
      if (squeeze) hold_seq++;
   endtask

   // Driver: record the item taken at this edge, then offer the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_overlays.push_back(predict_overlay(pixel_on_bus));
         if (!req_tvalid || req_tready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               pixel_on_bus = pending_pixels.pop_front();
               req_tdata  <= {{(REQ_DATA_W - $bits(pixel_type)){1'b0}}, pixel_on_bus};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check the result taken at this edge, then choose the next ready.
   always @(posedge clock) begin
      overlay_type want;
      overlay_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.frame_row  = rsp_tdata[12:0];
            got.frame_col  = rsp_tdata[25:13];
            got.out_luma   = rsp_tdata[33:26];
            got.out_cb     = rsp_tdata[41:34];
            got.out_cr     = rsp_tdata[49:42];
            got.write_luma = rsp_tuser[0];
            got.write_cb   = rsp_tuser[1];
            got.write_cr   = rsp_tuser[2];
            if (expected_overlays.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               want = expected_overlays.pop_front();
               if (got.frame_row != want.frame_row)
                  report_mismatch($sformatf("frame_row %0d, want %0d",
                                            got.frame_row, want.frame_row));
               if (got.frame_col != want.frame_col)
                  report_mismatch($sformatf("frame_col %0d, want %0d",
                                            got.frame_col, want.frame_col));
               if (got.out_luma != want.out_luma)
                  report_mismatch($sformatf("out_luma %0d, want %0d",
                                            got.out_luma, want.out_luma));
               if (got.out_cb != want.out_cb)
                  report_mismatch($sformatf("out_cb %0d, want %0d",
                                            got.out_cb, want.out_cb));
               if (got.out_cr != want.out_cr)
                  report_mismatch($sformatf("out_cr %0d, want %0d",
                                            got.out_cr, want.out_cr));
               if (got.write_luma != want.write_luma)
                  report_mismatch($sformatf("write_luma %0d, want %0d",
                                            got.write_luma, want.write_luma));
               if (got.write_cb != want.write_cb)
                  report_mismatch($sformatf("write_cb %0d, want %0d",
                                            got.write_cb, want.write_cb));
               if (got.write_cr != want.write_cr)
                  report_mismatch($sformatf("write_cr %0d, want %0d",
                                            got.write_cr, want.write_cr));
            end
            // upper bits of tdata are fill and must stay zero
            if (rsp_tdata[RSP_DATA_W-1:50] != '0)
               report_mismatch($sformatf("fill bits %0h", rsp_tdata[RSP_DATA_W-1:50]));
            results_seen++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: end the run once nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items under the reset settings: black, white, the primaries
      // and the chroma extremes, plus all four row/column parities.
      pending_pixels.push_back(make_pixel(0, 0, 0, 0, 0, 0, 0, 0));
      pending_pixels.push_back(make_pixel(1023, 1023, 255, 255, 255, 255, 255, 255));
      pending_pixels.push_back(make_pixel(0, 1, 255, 0, 0, 0, 255, 0));
      pending_pixels.push_back(make_pixel(1, 0, 0, 255, 0, 255, 0, 255));
      pending_pixels.push_back(make_pixel(1, 1, 0, 0, 255, 128, 128, 128));
      pending_pixels.push_back(make_pixel(2, 2, 255, 255, 0, 16, 240, 16));
      pending_pixels.push_back(make_pixel(2, 3, 0, 255, 255, 235, 16, 240));
      pending_pixels.push_back(make_pixel(682, 341, 255, 0, 255, 0, 0, 255));
      pending_pixels.push_back(make_pixel(341, 682, 128, 128, 128, 255, 0, 0));
      pending_pixels.push_back(make_pixel(1022, 1021, 1, 254, 1, 1, 254, 1));
      wait_idle();

      // Opacity extremes, a write to an index with no register, zero-sized and
      // single-pixel frames, offsets at the top of their range and frame sizes
      // past the clamp.
      run_phase(8'd255, 12'd0, 12'd0, 13'd1920, 13'd1080, 0, 0, 1'b0);
      run_phase(8'd0, 12'd0, 12'd0, 13'd64, 13'd32, 67, 0, 1'b0);
      run_phase(8'd128, 12'd100, 12'd37, 13'd200, 13'd150, 0, 67, 1'b0);
      run_phase(8'd1, 12'd4095, 12'd4095, 13'd8191, 13'd8191, 16, 16, 1'b1);
      wait_idle();
      write_reg(CSR_SPARE_INDEX, 13'($urandom_range(8191)));
      run_phase(8'd254, 12'd3, 12'd0, 13'd0, 13'd1080, 0, 0, 1'b0);
      run_phase(8'd200, 12'd3500, 12'd3073, 13'd4096, 13'd4097, 16, 16, 1'b0);
      run_phase(8'd255, 12'd0, 12'd0, 13'd1, 13'd1, 67, 0, 1'b0);
      run_phase(8'd77, 12'd513, 12'd2000, 13'd2500, 13'd0, 0, 67, 1'b1);
      run_phase(8'd170, 12'd1, 12'd2, 13'd4097, 13'd4096, 16, 16, 1'b0);

      // Drain, then give stray results a chance to show up.
      wait_idle();
      repeat (4 * DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
